// ===== rtl/rsd_pkg.sv =====
// Shared constants, register indexes and segment table for the radix seven-segment display.
package rsd_pkg;

  localparam int unsigned DIGITS_DEF     = 7;
  localparam int unsigned VALUE_BITS_DEF = 15;

  localparam int unsigned RADIX_W    = 5;
  localparam int unsigned DWELL_W    = 16;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned REM_W      = 4;
  localparam int unsigned POS_W      = 3;
  localparam int unsigned SEL_W      = 8;
  localparam int unsigned SEG_W      = 8;
  localparam int unsigned OUT_TDATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_RADIX = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DWELL = 1'd1;

  localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;
  localparam logic [DWELL_W-1:0] DWELL_RESET = 16'd1;

  localparam logic [SEL_W-1:0] SEL_TOP = 8'h80;

  localparam logic [SEG_W-1:0] SEG_TABLE [16] = '{
    8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8,
    8'h80, 8'h90, 8'h88, 8'h83, 8'hC6, 8'hA1, 8'h86, 8'h8E
  };

endpackage

// ===== rtl/rsd_div.sv =====
// Bit-serial restoring divider: one quotient bit per cycle, small radix divisor.
module rsd_div #(
  parameter int unsigned VALUE_BITS = rsd_pkg::VALUE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [VALUE_BITS-1:0]         dividend_i,
  input  logic [rsd_pkg::RADIX_W-1:0]   base_i,
  output logic                          done_o,
  output logic [VALUE_BITS-1:0]         quot_o,
  output logic [rsd_pkg::REM_W-1:0]     rem_o
);
  import rsd_pkg::*;

  localparam int unsigned CNT_W = $clog2(VALUE_BITS);

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [VALUE_BITS-1:0] quot_q, quot_d;
  logic [REM_W-1:0]      rem_q, rem_d;
  logic [REM_W:0]        trial;
  logic [REM_W:0]        diff;
  logic                  fits;

  assign trial = {rem_q, quot_q[VALUE_BITS-1]};
  assign fits  = trial >= base_i;
  assign diff  = trial - base_i;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quot_d = quot_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quot_d = dividend_i;
      rem_d  = '0;
    end else if (busy_q) begin
      quot_d = {quot_q[VALUE_BITS-2:0], fits};
      rem_d  = fits ? diff[REM_W-1:0] : trial[REM_W-1:0];
      cnt_d  = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(VALUE_BITS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

// ===== rtl/radix_seven_segment_display_top.sv =====
// Top level: digit sequencer, configuration registers and output register of the display driver.
//
//  channel  | direction | handshake                    | payload
//  ---------+-----------+------------------------------+-----------------------------------------
//  s_axis   | in        | s_axis_tvalid/tready         | tdata: value
//  m_axis   | out       | m_axis_tvalid/tready         | tdata: position, digit_select, segments;
//           |           |                              | tuser: show; tlast: last
//  cfg      | in        | cfg_we_i                     | cfg_idx_i, cfg_data_i
//
//  Each request gives DIGITS results. For a shown digit the bit-serial divider works through
//  the value, its done flag is registered, and then the output register loads.
//  Hold slots after the quotient reaches zero cost one cycle each. The next request is taken in
//  the cycle after the last result loads; while m_axis holds a result back, the sequencer waits.
//  Reset is asynchronous; radix returns to 10 and the sequencer to idle.
module radix_seven_segment_display_top #(
  parameter int unsigned DIGITS     = rsd_pkg::DIGITS_DEF,
  parameter int unsigned VALUE_BITS = rsd_pkg::VALUE_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [((VALUE_BITS+7)/8)*8-1:0]     s_axis_tdata,   // [VALUE_BITS-1:0] value
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [rsd_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,   // [2:0] position,
                                                              // [10:3] digit_select,
                                                              // [18:11] segments
  output logic                                m_axis_tuser,   // [0] show
  output logic                                m_axis_tlast,
  input  logic                                cfg_we_i,
  input  logic [rsd_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [rsd_pkg::CFG_DATA_W-1:0]      cfg_data_i
);
  import rsd_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;
  localparam logic [1:0] ST_HOLD = 2'd3;

  logic [1:0]            state_q, state_d;
  logic [RADIX_W-1:0]    radix_q, radix_d;
  logic [DWELL_W-1:0]    dwell_q, dwell_d;
  logic [POS_W-1:0]      slot_q, slot_d;
  logic [VALUE_BITS-1:0] val_q, val_d;

  logic                  m_valid_q, m_valid_d;
  logic [POS_W-1:0]      pos_q, pos_d;
  logic [SEL_W-1:0]      sel_q, sel_d;
  logic [SEG_W-1:0]      seg_q, seg_d;
  logic                  show_q, show_d;
  logic                  last_q, last_d;

  logic [RADIX_W-1:0]    base;
  logic                  div_start;
  logic                  div_done;
  logic [VALUE_BITS-1:0] div_quot;
  logic [REM_W-1:0]      div_rem;
  logic                  out_free;
  logic                  slot_last;
  logic                  in_take;

  rsd_div #(
    .VALUE_BITS(VALUE_BITS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (val_d),
    .base_i     (base),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  assign base = (radix_q < RADIX_MIN) ? RADIX_MIN :
                (radix_q > RADIX_MAX) ? RADIX_MAX : radix_q;

  assign out_free  = !m_valid_q || m_axis_tready;
  assign slot_last = slot_q == POS_W'(DIGITS - 1);
  assign in_take   = s_axis_tvalid && (state_q == ST_IDLE);

  always_comb begin
    radix_d = radix_q;
    dwell_d = dwell_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_RADIX: radix_d = cfg_data_i[RADIX_W-1:0];
        CFG_DWELL: dwell_d = cfg_data_i[DWELL_W-1:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    state_d   = state_q;
    slot_d    = slot_q;
    val_d     = val_q;
    div_start = 1'b0;
    m_valid_d = m_valid_q && !m_axis_tready;
    pos_d     = pos_q;
    sel_d     = sel_q;
    seg_d     = seg_q;
    show_d    = show_q;
    last_d    = last_q;
    case (state_q)
      ST_IDLE: begin
        if (in_take) begin
          val_d     = s_axis_tdata[VALUE_BITS-1:0];
          slot_d    = '0;
          div_start = 1'b1;
          state_d   = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          pos_d     = slot_q;
          sel_d     = SEL_TOP >> slot_q;
          seg_d     = SEG_TABLE[div_rem];
          show_d    = 1'b1;
          last_d    = slot_last;
          slot_d    = slot_q + 1'b1;
          val_d     = div_quot;
          if (slot_last) begin
            state_d = ST_IDLE;
          end else if (div_quot == '0) begin
            state_d = ST_HOLD;
          end else begin
            div_start = 1'b1;
            state_d   = ST_DIV;
          end
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          pos_d     = slot_q;
          sel_d     = '0;
          seg_d     = '0;
          show_d    = 1'b0;
          last_d    = slot_last;
          slot_d    = slot_q + 1'b1;
          if (slot_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      radix_q   <= RADIX_RESET;
      dwell_q   <= DWELL_RESET;
      slot_q    <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      radix_q   <= radix_d;
      dwell_q   <= dwell_d;
      slot_q    <= slot_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q  <= val_d;
    pos_q  <= pos_d;
    sel_q  <= sel_d;
    seg_q  <= seg_d;
    show_q <= show_d;
    last_q <= last_d;
  end

  assign s_axis_tready = state_q == ST_IDLE;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {(OUT_TDATA_W - POS_W - SEL_W - SEG_W)'(0), seg_q, sel_q, pos_q};
  assign m_axis_tuser  = show_q;
  assign m_axis_tlast  = last_q;

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the radix seven-segment display driver.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rsd_pkg::*;

  localparam int unsigned NUM_SLOTS   = 7;
  localparam int unsigned HOLD_CYCLES = 2000;
  localparam int unsigned IDLE_GAP    = 40;
  localparam int unsigned END_SLACK   = 200;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned MAX_REPORTS = 10;

  localparam logic [1:0] RX_ALWAYS  = 2'd0;
  localparam logic [1:0] RX_RANDOM  = 2'd1;
  localparam logic [1:0] RX_PATTERN = 2'd2;

  typedef struct packed {
    logic [2:0] position;
    logic [7:0] digit_select;
    logic [7:0] segments;
    logic       show;
    logic       is_last;
  } slot_t;

  localparam logic [7:0] SEG_CODE [16] = '{
    8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8,
    8'h80, 8'h90, 8'h88, 8'h83, 8'hC6, 8'hA1, 8'h86, 8'h8E
  };

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [15:0]            s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tuser;
  logic                   m_axis_tlast;
  logic                   cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i = '0;

  logic [4:0]  model_radix = RADIX_RESET;
  logic [15:0] model_dwell = DWELL_RESET;
  slot_t       slots_due[$];
  slot_t       seen_slot;
  slot_t       due_slot;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;

  logic [1:0]  rx_mode = RX_ALWAYS;
  logic [15:0] rx_mask = 16'hFFFF;
  logic [3:0]  rx_tick = '0;
  int unsigned hold_reqs = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;

  radix_seven_segment_display_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("radix_seven_segment_display_top regression: fail");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    rx_tick <= rx_tick + 4'd1;
    if (hold_seen != hold_reqs) begin
      hold_seen     <= hold_reqs;
      hold_left     <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_ALWAYS: m_axis_tready <= 1'b1;
        RX_RANDOM: m_axis_tready <= ($urandom_range(0, 3) != 0);
        default:   m_axis_tready <= rx_mask[rx_tick];
      endcase
    end
  end

  function automatic logic [4:0] eff_radix();
    if (model_radix < RADIX_MIN) return RADIX_MIN;
    if (model_radix > RADIX_MAX) return RADIX_MAX;
    return model_radix;
  endfunction

  function automatic void predict_digits(input logic [14:0] value);
    logic [4:0]  base;
    logic [14:0] rem;
    logic [3:0]  digit;
    bit          done;
    slot_t       s;
    base = eff_radix();
    rem  = value;
    done = 1'b0;
    for (int n = 0; n < NUM_SLOTS; n++) begin
      s          = '0;
      s.position = n[2:0];
      s.is_last  = (n == NUM_SLOTS - 1);
      if (!done) begin
        digit          = 4'(rem % base);
        s.digit_select = SEL_TOP >> n;
        s.segments     = SEG_CODE[digit];
        s.show         = 1'b1;
        rem            = rem / base;
        done           = (rem == 0);
      end
      slots_due.push_back(s);
    end
  endfunction

  function automatic void flag_mismatch(input string what, input slot_t want, input slot_t got);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("%0t %s: expected pos=%0d sel=%h seg=%h show=%b last=%b", $realtime, what,
               want.position, want.digit_select, want.segments, want.show, want.is_last);
      $display("%0t %s: actual   pos=%0d sel=%h seg=%h show=%b last=%b", $realtime, what,
               got.position, got.digit_select, got.segments, got.show, got.is_last);
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      seen_slot.position     = m_axis_tdata[2:0];
      seen_slot.digit_select = m_axis_tdata[10:3];
      seen_slot.segments     = m_axis_tdata[18:11];
      seen_slot.show         = m_axis_tuser;
      seen_slot.is_last      = m_axis_tlast;
      if (slots_due.size() == 0) begin
        flag_mismatch("unexpected slot", '0, seen_slot);
      end else begin
        due_slot = slots_due.pop_front();
        if (seen_slot !== due_slot) flag_mismatch("slot mismatch", due_slot, seen_slot);
      end
    end
  end

  // hold valid high on return so a following request can go back to back
  task automatic send_value(input logic [14:0] value);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, value};
    @(posedge clk_i);
    while (s_axis_tready !== 1'b1) @(posedge clk_i);
    predict_digits(value);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (slots_due.size() != 0) @(posedge clk_i);
    repeat (IDLE_GAP) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    if (idx == CFG_RADIX) model_radix = data[4:0];
    else model_dwell = data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_radix(input logic [CFG_DATA_W-1:0] data);
    wait_idle();
    write_reg(CFG_RADIX, data);
  endtask

  function automatic logic [14:0] pick_value();
    int unsigned base;
    int unsigned p;
    int unsigned k;
    base = eff_radix();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 15'($urandom_range(0, 32767));
      4:          return 15'($urandom_range(0, base * base));
      5:          return '0;
      6:          return 15'h7FFF;
      7, 8: begin
        p = 1;
        k = $urandom_range(1, 14);
        while (k > 0 && p * base <= 32767) begin
          p = p * base;
          k--;
        end
        return 15'(p - $urandom_range(0, 1));
      end
      default:    return 15'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic test_default_radix();
    rx_mode <= RX_RANDOM;
    send_value(15'd0);
    send_value(15'h7FFF);
    send_value(15'd9);
    send_value(15'd10);
    send_value(15'd1000);
  endtask

  task automatic test_extreme_radices();
    set_radix(16'(RADIX_MIN));
    send_value(15'h7FFF);
    send_value(15'd0);
    send_value(15'd127);
    send_value(15'd128);
    send_value(15'd1);
    set_radix(16'(RADIX_MAX));
    send_value(15'h7FFF);
    send_value(15'd15);
    send_value(15'd16);
    send_value(15'h7DEF);
    send_value(15'h4ABC);
  endtask

  task automatic test_clamped_radix();
    set_radix(16'd0);
    send_value(15'd5);
    set_radix(16'd1);
    send_value(15'd6);
    set_radix(16'd17);
    send_value(15'd255);
    set_radix(16'd31);
    send_value(15'd4095);
    set_radix(16'hFFEA);
    send_value(15'h7FFF);
  endtask

  task automatic test_dwell_register();
    wait_idle();
    write_reg(CFG_DWELL, 16'h0000);
    write_reg(CFG_DWELL, 16'hFFFF);
    write_reg(CFG_RADIX, 16'd8);
    send_value(15'h7FFF);
    set_radix(16'd3);
    send_value(15'h7FFF);
  endtask

  task automatic test_output_stall();
    set_radix(16'd10);
    rx_mode   <= RX_ALWAYS;
    hold_reqs <= hold_reqs + 1;
    for (int i = 0; i < 12; i++) send_value(15'($urandom_range(0, 32767)));
    wait_idle();
  endtask

  task automatic run_random_phase(input int unsigned count);
    int unsigned burst_left;
    int unsigned gap;
    burst_left = $urandom_range(1, 12);
    for (int unsigned i = 0; i < count; i++) begin
      send_value(pick_value());
      burst_left--;
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 120) : $urandom_range(0, 20);
        if (gap != 0) begin
          s_axis_tvalid <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
        burst_left = $urandom_range(1, 12);
      end
    end
  endtask

  task automatic test_random_radices();
    int radix_plan[12] = '{10, 2, 16, 3, 7, 8, 5, 13, 0, 31, 17, 11};
    for (int ph = 0; ph < 12; ph++) begin
      wait_idle();
      write_reg(CFG_DWELL, 16'($urandom_range(0, 65535)));
      write_reg(CFG_RADIX, 16'(radix_plan[ph]) | (16'($urandom_range(0, 2047)) << 5));
      rx_mode <= 2'(ph % 3);
      rx_mask <= 16'($urandom_range(1, 65535));
      run_random_phase(32);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_default_radix();
    test_extreme_radices();
    test_clamped_radix();
    test_dwell_register();
    test_output_stall();
    test_random_radices();
    s_axis_tvalid <= 1'b0;
    while (slots_due.size() != 0) @(posedge clk_i);
    repeat (END_SLACK) @(posedge clk_i);
    if (mismatches == 0 && slots_due.size() == 0) begin
      $display("radix_seven_segment_display_top regression: pass");
    end else begin
      $display("radix_seven_segment_display_top regression: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/rsd_pkg.sv
rtl/rsd_div.sv
rtl/radix_seven_segment_display_top.sv
tb/sv/tb.sv
